@@ hw/rtl/sctk_pkg.sv @@
// Shared constants and codes for the soft compare tick timekeeper.
`timescale 1ns / 1ps
`default_nettype none
package sctk_pkg;

    localparam int COUNTER_WIDTH_DEF = 32;
    localparam int DIVISOR_WIDTH     = 32;
    localparam int SEC_WIDTH         = 32;
    localparam int USEC_WIDTH        = 20;
    localparam int MODE_WIDTH        = 2;
    localparam int CFG_ADDR_WIDTH    = 2;
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int IN_DATA_WIDTH     = 88;
    localparam int OUT_DATA_WIDTH    = 88;

    localparam logic [USEC_WIDTH-1:0]    USEC_PER_SEC        = 20'd1000000;
    localparam logic [DIVISOR_WIDTH-1:0] TICK_PERIOD_RST     = 32'd1000000;
    localparam logic [DIVISOR_WIDTH-1:0] CYCLES_PER_USEC_RST = 32'd100;

    localparam logic [MODE_WIDTH-1:0] MODE_START = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_POLL  = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_TICK_PERIOD     = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CYCLES_PER_USEC = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_CLOCK_ENABLE    = 2'd2;

endpackage
`default_nettype wire

@@ hw/rtl/sctk_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sctk_divider #(
    parameter int DIVIDEND_WIDTH = 33
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    input  wire  [DIVIDEND_WIDTH-1:0]            dividend,
    input  wire  [sctk_pkg::DIVISOR_WIDTH-1:0]   divisor,
    output logic                                 done,
    output logic [DIVIDEND_WIDTH-1:0]            quotient,
    output logic [sctk_pkg::DIVISOR_WIDTH-1:0]   remainder
);
    import sctk_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_WIDTH + 1);

    logic [DIVIDEND_WIDTH-1:0] quo_reg;
    logic [DIVISOR_WIDTH-1:0]  rem_reg;
    logic [DIVISOR_WIDTH-1:0]  dvs_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [DIVISOR_WIDTH:0]    trial;
    logic                      fits;
    logic [DIVISOR_WIDTH:0]    diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_WIDTH-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract when it fits
            quo_reg <= {quo_reg[DIVIDEND_WIDTH-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ hw/rtl/soft_compare_tick_timekeeper_unit.sv @@
// Polled tick timer with microsecond interpolation, top level.
//
// Each beat on the input stream is a start, poll or read command selected by s_tuser.
// One serial divider (one quotient bit per cycle, DW = max(COUNTER_WIDTH, 20) + 1 quotient
// bits) does the division; the seconds carry of a read is found by a registered reciprocal
// multiply. A start, an unknown command and a poll that counts nothing go from S_PREP
// straight to S_FIN. A counting poll waits on the divider in S_DIV1 first. A read runs
// S_DIV1, S_SUM and S_BUMP, with S_NORM between the last two when the microseconds carry
// into the seconds; a read whose sample is behind the last tick skips the divider.
// One command is worked on at a time; the result register lets the next command be taken
// while a finished result waits on the output.
`timescale 1ns / 1ps
`default_nettype none
module soft_compare_tick_timekeeper_unit #(
    parameter int COUNTER_WIDTH = sctk_pkg::COUNTER_WIDTH_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // counter_sample[31:0], base_sec[63:32], base_usec[83:64], zero fill
    input  wire  [sctk_pkg::IN_DATA_WIDTH-1:0]     s_tdata,
    // mode[1:0]
    input  wire  [sctk_pkg::MODE_WIDTH-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // ticks_elapsed[31:0], time_sec[63:32], time_usec[83:64], zero fill
    output logic [sctk_pkg::OUT_DATA_WIDTH-1:0]    m_tdata,
    // counter_behind[0]
    output logic                                   m_tuser,
    input  wire                                    cfg_we,
    input  wire  [sctk_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  wire  [sctk_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata
);
    import sctk_pkg::*;

    localparam int CW = COUNTER_WIDTH;
    localparam int DW = ((CW > USEC_WIDTH) ? CW : USEC_WIDTH) + 1;
    localparam int WW = ((CW > DIVISOR_WIDTH) ? CW : DIVISOR_WIDTH) + 1;
    localparam int TW = ((DW > SEC_WIDTH) ? DW : SEC_WIDTH) + 1;

    // x / 1000000 = (x >> 6) / 15625, exact for x below 2^34 with this reciprocal
    localparam int          NX_W       = 34;
    localparam int          NP_W       = 57;
    localparam int          NQ_W       = 15;
    localparam logic [28:0] USEC_RECIP = 29'd281474977;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_NORM = 3'd4;
    localparam logic [2:0] S_BUMP = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [DIVISOR_WIDTH-1:0] tick_period_reg;
    logic [DIVISOR_WIDTH-1:0] cycles_per_usec_reg;
    logic                     clock_enable_reg;

    logic [CW-1:0]            next_compare_reg;
    logic [SEC_WIDTH-1:0]     last_sec_reg;
    logic [USEC_WIDTH-1:0]    last_usec_reg;

    logic [2:0]               state_reg;
    logic [MODE_WIDTH-1:0]    mode_reg;
    logic [CW-1:0]            sample_reg;
    logic [CW-1:0]            base_reg;
    logic [DW-1:0]            usec_acc_reg;
    logic [SEC_WIDTH-1:0]     sec_acc_reg;
    logic [SEC_WIDTH-1:0]     ticks_reg;
    logic                     behind_reg;
    logic [NP_W-1:0]          norm_prod_reg;

    logic                     out_valid_reg;
    logic [SEC_WIDTH-1:0]     out_ticks_reg;
    logic [SEC_WIDTH-1:0]     out_sec_reg;
    logic [USEC_WIDTH-1:0]    out_usec_reg;
    logic                     out_behind_reg;

    logic [DIVISOR_WIDTH-1:0] per_eff;
    logic [DIVISOR_WIDTH-1:0] rate_eff;
    logic [WW-1:0]            per_w;
    logic [WW-1:0]            in_sample_w;
    logic [WW-1:0]            start_w;
    logic [CW-1:0]            diff;
    logic                     accept;
    logic                     out_free;
    logic                     out_load;

    logic                     div_start;
    logic [DW-1:0]            div_dividend;
    logic [DIVISOR_WIDTH-1:0] div_divisor;
    logic                     div_done;
    logic [DW-1:0]            div_quo;
    logic [DIVISOR_WIDTH-1:0] div_rem;

    logic [TW-1:0]            quo_t;
    logic [TW-1:0]            ticks_t;
    logic [WW-1:0]            nc_poll_w;
    logic [WW-1:0]            nc_start_w;
    logic [USEC_WIDTH:0]      usec_inc;
    logic                     bump;
    logic                     need_norm;
    logic [NX_W-1:0]          norm_x;
    logic [NQ_W-1:0]          norm_quo;
    logic [NX_W-1:0]          norm_rem;

    assign per_eff     = (tick_period_reg == '0) ? DIVISOR_WIDTH'(1) : tick_period_reg;
    assign rate_eff    = (cycles_per_usec_reg == '0) ? DIVISOR_WIDTH'(1) : cycles_per_usec_reg;
    assign per_w       = WW'(per_eff);
    assign in_sample_w = WW'(s_tdata[31:0]);
    assign start_w     = WW'(next_compare_reg) - per_w;
    assign diff        = sample_reg - base_reg;
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !out_valid_reg || m_tready;
    assign out_load    = (state_reg == S_FIN) && out_free;
    assign s_tready    = (state_reg == S_IDLE);

    assign quo_t      = TW'(div_quo);
    assign ticks_t    = quo_t + TW'(1);
    assign nc_poll_w  = WW'(sample_reg) - WW'(div_rem) + per_w;
    assign nc_start_w = WW'(sample_reg) + per_w;
    assign usec_inc   = {1'b0, last_usec_reg} + (USEC_WIDTH+1)'(1);
    assign bump       = (sec_acc_reg == last_sec_reg) &&
                        (usec_acc_reg[USEC_WIDTH-1:0] <= last_usec_reg);

    assign need_norm = (usec_acc_reg >= DW'(USEC_PER_SEC));
    assign norm_x    = NX_W'(usec_acc_reg);
    assign norm_quo  = norm_prod_reg[NP_W-1:NP_W-NQ_W];
    assign norm_rem  = norm_x - (NX_W'(norm_quo) * NX_W'(USEC_PER_SEC));

    // feed the shared divider with the elapsed count
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DW'(diff);
        div_divisor  = per_eff;
        unique case (state_reg)
            S_PREP:
            begin
                if (mode_reg == MODE_POLL)
                begin
                    div_start = clock_enable_reg && (diff != '0) && !diff[CW-1];
                end
                else if (mode_reg == MODE_READ)
                begin
                    div_start   = !diff[CW-1];
                    div_divisor = rate_eff;
                end
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    sctk_divider #(
        .DIVIDEND_WIDTH (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg     <= TICK_PERIOD_RST;
            cycles_per_usec_reg <= CYCLES_PER_USEC_RST;
            clock_enable_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TICK_PERIOD:     tick_period_reg     <= cfg_wdata;
                REG_CYCLES_PER_USEC: cycles_per_usec_reg <= cfg_wdata;
                REG_CLOCK_ENABLE:    clock_enable_reg    <= cfg_wdata[0];
                default:             clock_enable_reg    <= clock_enable_reg;
            endcase
        end
    end

    // sequencer and timekeeping state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            next_compare_reg <= '0;
            last_sec_reg     <= '0;
            last_usec_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (mode_reg == MODE_START)
                    begin
                        next_compare_reg <= nc_start_w[CW-1:0];
                    end
                    if (div_start)
                    begin
                        state_reg <= S_DIV1;
                    end
                    else if (mode_reg == MODE_READ)
                    begin
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        if (mode_reg == MODE_POLL)
                        begin
                            next_compare_reg <= nc_poll_w[CW-1:0];
                            state_reg        <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM:
                begin
                    state_reg <= need_norm ? S_NORM : S_BUMP;
                end
                S_NORM:
                begin
                    state_reg <= S_BUMP;
                end
                S_BUMP:
                begin
                    if (bump)
                    begin
                        if (usec_inc == {1'b0, USEC_PER_SEC})
                        begin
                            last_sec_reg  <= sec_acc_reg + SEC_WIDTH'(1);
                            last_usec_reg <= '0;
                        end
                        else
                        begin
                            last_usec_reg <= usec_inc[USEC_WIDTH-1:0];
                        end
                    end
                    else
                    begin
                        last_sec_reg  <= sec_acc_reg;
                        last_usec_reg <= usec_acc_reg[USEC_WIDTH-1:0];
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_reg     <= s_tuser;
                    sample_reg   <= in_sample_w[CW-1:0];
                    base_reg     <= (s_tuser == MODE_READ) ? start_w[CW-1:0] : next_compare_reg;
                    sec_acc_reg  <= (s_tuser == MODE_READ) ? s_tdata[63:32] : '0;
                    usec_acc_reg <= (s_tuser == MODE_READ) ? DW'(s_tdata[83:64]) : '0;
                    ticks_reg    <= '0;
                    behind_reg   <= 1'b0;
                end
            end
            S_PREP:
            begin
                if (mode_reg == MODE_READ)
                begin
                    behind_reg <= diff[CW-1];
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    if (mode_reg == MODE_POLL)
                    begin
                        // saturate the reported count, the compare point takes the full one
                        ticks_reg <= (|ticks_t[TW-1:SEC_WIDTH]) ? '1 : ticks_t[SEC_WIDTH-1:0];
                    end
                    else
                    begin
                        usec_acc_reg <= usec_acc_reg + div_quo;
                    end
                end
            end
            S_SUM:
            begin
                norm_prod_reg <= NP_W'(norm_x[NX_W-1:6]) * NP_W'(USEC_RECIP);
            end
            S_NORM:
            begin
                // carry whole seconds, keep the leftover microseconds
                sec_acc_reg  <= sec_acc_reg + SEC_WIDTH'(norm_quo);
                usec_acc_reg <= DW'(norm_rem);
            end
            S_BUMP:
            begin
                if (bump)
                begin
                    if (usec_inc == {1'b0, USEC_PER_SEC})
                    begin
                        sec_acc_reg  <= sec_acc_reg + SEC_WIDTH'(1);
                        usec_acc_reg <= '0;
                    end
                    else
                    begin
                        usec_acc_reg <= DW'(usec_inc);
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_ticks_reg  <= ticks_reg;
                    out_sec_reg    <= sec_acc_reg;
                    out_usec_reg   <= usec_acc_reg[USEC_WIDTH-1:0];
                    out_behind_reg <= behind_reg;
                end
            end
            default:
            begin
                behind_reg <= behind_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_WIDTH'({out_usec_reg, out_sec_reg, out_ticks_reg});
    assign m_tuser  = out_behind_reg;

endmodule
`default_nettype wire
